@@ rtl/ose_pkg.sv @@
// ============================================================================
// ose_pkg - shared definitions for the operand stack engine
// Stack sizing, field widths, command and status codes.
// ============================================================================
package ose_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam int WORD_W      = 64;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_W     = 8;

    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 80;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_DUP   = 3'd3,
        CMD_SWAP  = 3'd4,
        CMD_CLEAR = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SHORT = 2'd3
    } status_t;

endpackage

@@ rtl/operand_stack_engine.sv @@
// ============================================================================
// operand_stack_engine - LIFO stack of raw 64-bit words
// Push, pop, peek, duplicate, swap and clear; one result beat per command.
// ============================================================================
// Result: registered; a beat appears in the cycle after its command is taken.
// Throughput: one command per cycle unless results stall; the top two entries
//   live in registers; the entry below them is prefetched from stack memory.
// Reset: aresetn (synchronous, active low) empties the stack and drops any
//   pending result; memory contents are not cleared and need no sweep.
// ============================================================================
module operand_stack_engine (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata, low bit up: command[2:0], push_word[66:3], zero pad[71:67]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ose_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata, low bit up: read_word[63:0], status[65:64], depth[73:66],
    // zero pad[79:74]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ose_pkg::M_TDATA_W-1:0]  m_tdata
);

    // ------------------------------------------------------------------
    // Stack state: entry count, top and next-on-stack words in registers.
    // Entries at index depth-3 and below live in the memory.
    // ------------------------------------------------------------------
    logic [ose_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ose_pkg::WORD_W-1:0]  tos_reg, tos_next;
    logic [ose_pkg::WORD_W-1:0]  nos_reg, nos_next;

    // Memory with registered read and a write-to-read bypass
    logic [ose_pkg::WORD_W-1:0]  mem [ose_pkg::STACK_DEPTH];
    logic [ose_pkg::WORD_W-1:0]  rd_data_reg;
    logic                        byp_reg;
    logic [ose_pkg::WORD_W-1:0]  byp_data_reg;
    logic                        mem_we;
    logic [ose_pkg::ADDR_W-1:0]  mem_waddr;
    logic [ose_pkg::ADDR_W-1:0]  mem_raddr;
    logic [ose_pkg::CNT_W-1:0]   waddr_full;
    logic [ose_pkg::CNT_W-1:0]   raddr_full;
    logic [ose_pkg::WORD_W-1:0]  third_word;

    // Result register
    logic                        m_valid_reg, m_valid_next;
    logic [ose_pkg::M_TDATA_W-1:0] m_data_reg;

    logic                        s_acc;
    ose_pkg::cmd_t               cmd;
    logic [ose_pkg::WORD_W-1:0]  push_word;
    logic [ose_pkg::WORD_W-1:0]  rd_word;
    ose_pkg::status_t            status;
    logic [ose_pkg::CNT_W+ose_pkg::DEPTH_W-1:0] depth_wide;

    // Take a new command whenever the result slot is free or draining
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_acc     = s_tvalid && s_tready;

    assign cmd       = ose_pkg::cmd_t'(s_tdata[ose_pkg::CMD_W-1:0]);
    assign push_word = s_tdata[ose_pkg::CMD_W +: ose_pkg::WORD_W];

    // Third entry from the top: fresh write data wins over the stale read
    assign third_word = byp_reg ? byp_data_reg : rd_data_reg;

    // Spill next-on-stack into the memory at depth-2 on push and duplicate
    assign waddr_full = cnt_reg - ose_pkg::CNT_W'(2);
    assign mem_waddr  = waddr_full[ose_pkg::ADDR_W-1:0];
    // Prefetch the entry that will sit third from the top next cycle
    assign raddr_full = cnt_next - ose_pkg::CNT_W'(3);
    assign mem_raddr  = raddr_full[ose_pkg::ADDR_W-1:0];

    always_comb begin
        cnt_next = cnt_reg;
        tos_next = tos_reg;
        nos_next = nos_reg;
        mem_we   = 1'b0;
        rd_word  = '0;
        status   = ose_pkg::ST_OK;
        if (s_acc) begin
            unique case (cmd)
                ose_pkg::CMD_PUSH: begin
                    if (cnt_reg < ose_pkg::FULL_CNT) begin
                        mem_we   = (cnt_reg >= ose_pkg::CNT_W'(2));
                        nos_next = tos_reg;
                        tos_next = push_word;
                        cnt_next = cnt_reg + ose_pkg::CNT_W'(1);
                    end else begin
                        status = ose_pkg::ST_FULL;
                    end
                end
                ose_pkg::CMD_POP: begin
                    if (cnt_reg != '0) begin
                        rd_word  = tos_reg;
                        tos_next = nos_reg;
                        nos_next = third_word;
                        cnt_next = cnt_reg - ose_pkg::CNT_W'(1);
                    end else begin
                        status = ose_pkg::ST_EMPTY;
                    end
                end
                ose_pkg::CMD_PEEK: begin
                    if (cnt_reg != '0) begin
                        rd_word = tos_reg;
                    end else begin
                        status = ose_pkg::ST_EMPTY;
                    end
                end
                ose_pkg::CMD_DUP: begin
                    if (cnt_reg == '0) begin
                        status = ose_pkg::ST_EMPTY;
                    end else if (cnt_reg >= ose_pkg::FULL_CNT) begin
                        status = ose_pkg::ST_FULL;
                    end else begin
                        mem_we   = (cnt_reg >= ose_pkg::CNT_W'(2));
                        nos_next = tos_reg;
                        cnt_next = cnt_reg + ose_pkg::CNT_W'(1);
                    end
                end
                ose_pkg::CMD_SWAP: begin
                    if (cnt_reg > ose_pkg::CNT_W'(1)) begin
                        tos_next = nos_reg;
                        nos_next = tos_reg;
                    end else begin
                        status = ose_pkg::ST_SHORT;
                    end
                end
                ose_pkg::CMD_CLEAR: begin
                    cnt_next = '0;
                end
                default: begin
                    // unused codes: leave the stack alone, report ok
                end
            endcase
        end
    end

    // Hold the result until the sink takes it
    assign m_valid_next = s_acc || (m_valid_reg && !m_tready);
    assign depth_wide   = {{ose_pkg::DEPTH_W{1'b0}}, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            byp_reg     <= mem_we && (mem_waddr == mem_raddr);
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg      <= tos_next;
        nos_reg      <= nos_next;
        byp_data_reg <= nos_reg;
        if (s_acc) begin
            m_data_reg <= {{(ose_pkg::M_TDATA_W - ose_pkg::WORD_W - ose_pkg::STATUS_W
                             - ose_pkg::DEPTH_W){1'b0}},
                           depth_wide[ose_pkg::DEPTH_W-1:0], status, rd_word};
        end
    end

    // Stack memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= nos_reg;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/ose_checker.sv @@
// ============================================================================
// ose_checker - port-level checks for the operand stack engine
// Watches the result stream for status and depth consistency.
// ============================================================================
module ose_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ose_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [ose_pkg::DEPTH_W-1:0] FULL_DEPTH =
        ose_pkg::DEPTH_W'(ose_pkg::STACK_DEPTH);

    logic [ose_pkg::WORD_W-1:0]   out_word;
    logic [ose_pkg::STATUS_W-1:0] out_status;
    logic [ose_pkg::DEPTH_W-1:0]  out_depth;

    assign out_word   = m_tdata[ose_pkg::WORD_W-1:0];
    assign out_status = m_tdata[ose_pkg::WORD_W +: ose_pkg::STATUS_W];
    assign out_depth  = m_tdata[ose_pkg::WORD_W + ose_pkg::STATUS_W +: ose_pkg::DEPTH_W];

    // Reset drops any pending result beat
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // A stalled result beat stays put
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Full refusal only at full depth, with no word read
    a_full_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status == ose_pkg::ST_FULL |->
            out_depth == FULL_DEPTH && out_word == '0)
        else $error("full status with wrong depth or word");

    // Empty refusal leaves the stack empty and reads zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status == ose_pkg::ST_EMPTY |->
            out_depth == '0 && out_word == '0)
        else $error("empty status with nonzero depth or word");

    // Short swap only below two entries
    a_short_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status == ose_pkg::ST_SHORT |->
            (out_depth == 8'd0 || out_depth == 8'd1) && out_word == '0)
        else $error("short status with two or more entries");

endmodule

bind operand_stack_engine ose_checker u_ose_checker (.*);

@@ tb/operand_stack_engine_tb.sv @@
// ============================================================================
// operand_stack_engine_tb - self-checking bench for the operand stack engine
// Walks a short table of directed commands (empty, single entry, swap and
// clear corners, spare codes), then about 1400 random commands mixed in
// fill, drain and even phases so the stack runs full and empty many times.
// A shadow stack predicts every result beat; the command side sends in bursts
// with random gaps and the result side stalls on its own pattern.
// ============================================================================
module operand_stack_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Spare command codes: the block must ignore them and still answer.
    localparam logic [ose_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [ose_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam int          RANDOM_CMDS = 1400;
    localparam int          DRAIN_WAIT  = 16;
    localparam int          SHOW_LIMIT  = 10;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [ose_pkg::WORD_W-1:0]  word;
        ose_pkg::status_t            status;
        logic [ose_pkg::DEPTH_W-1:0] depth;
    } result_t;

    typedef struct packed {
        logic [ose_pkg::CMD_W-1:0]  cmd;
        logic [ose_pkg::WORD_W-1:0] word;
        logic                       typed;   // row carries its own answer
        result_t                    want;
    } dir_row_t;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    // Directed rows. Answers are typed in only where they are obvious; the
    // rest fall through to the shadow stack.
    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ose_pkg::CMD_POP,   ALL_ONES, 1'b1, '{64'd0, ose_pkg::ST_EMPTY, 8'd0}},
        '{ose_pkg::CMD_PEEK,  64'd0,    1'b1, '{64'd0, ose_pkg::ST_EMPTY, 8'd0}},
        '{ose_pkg::CMD_DUP,   ALL_ONES, 1'b1, '{64'd0, ose_pkg::ST_EMPTY, 8'd0}},
        '{ose_pkg::CMD_SWAP,  64'd0,    1'b1, '{64'd0, ose_pkg::ST_SHORT, 8'd0}},
        '{CMD_SPARE6,         ALL_ONES, 1'b1, '{64'd0, ose_pkg::ST_OK,    8'd0}},
        '{CMD_SPARE7,         64'd0,    1'b1, '{64'd0, ose_pkg::ST_OK,    8'd0}},
        '{ose_pkg::CMD_PUSH,  ALL_ONES, 1'b1, '{64'd0, ose_pkg::ST_OK,    8'd1}},
        '{ose_pkg::CMD_SWAP,  64'd0,    1'b1, '{64'd0, ose_pkg::ST_SHORT, 8'd1}},
        '{ose_pkg::CMD_PEEK,  64'd0,    1'b1, '{ALL_ONES, ose_pkg::ST_OK, 8'd1}},
        '{ose_pkg::CMD_PUSH,  64'd0,    1'b1, '{64'd0, ose_pkg::ST_OK,    8'd2}},
        '{ose_pkg::CMD_SWAP,  ALL_ONES, 1'b1, '{64'd0, ose_pkg::ST_OK,    8'd2}},
        '{ose_pkg::CMD_POP,   64'd0,    1'b1, '{ALL_ONES, ose_pkg::ST_OK, 8'd1}},
        '{ose_pkg::CMD_POP,   64'd0,    1'b1, '{64'd0, ose_pkg::ST_OK,    8'd0}},
        '{ose_pkg::CMD_PUSH,  64'h8000_0000_0000_0001, 1'b1,
          '{64'd0, ose_pkg::ST_OK, 8'd1}},
        '{ose_pkg::CMD_DUP,   64'd0,    1'b1, '{64'd0, ose_pkg::ST_OK,    8'd2}},
        '{ose_pkg::CMD_PUSH,  64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{ose_pkg::CMD_SWAP,  64'd0,    1'b0, '0},
        '{ose_pkg::CMD_POP,   64'd0,    1'b0, '0},
        '{ose_pkg::CMD_POP,   64'd0,    1'b0, '0},
        '{ose_pkg::CMD_CLEAR, ALL_ONES, 1'b1, '{64'd0, ose_pkg::ST_OK,    8'd0}},
        '{ose_pkg::CMD_POP,   64'd0,    1'b1, '{64'd0, ose_pkg::ST_EMPTY, 8'd0}},
        '{ose_pkg::CMD_PUSH,  64'h5555_AAAA_5555_AAAA, 1'b1,
          '{64'd0, ose_pkg::ST_OK, 8'd1}},
        '{CMD_SPARE7,         ALL_ONES, 1'b1, '{64'd0, ose_pkg::ST_OK,    8'd1}},
        '{ose_pkg::CMD_POP,   64'd0,    1'b0, '0}
    };

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // s_tdata, low bit up: command[2:0], push_word[66:3], zero pad[71:67]
    logic [ose_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // m_tdata, low bit up: read_word[63:0], status[65:64], depth[73:66],
    // zero pad[79:74]
    logic [ose_pkg::M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the stack contents and fill level.
    logic [ose_pkg::WORD_W-1:0] shadow_words [ose_pkg::STACK_DEPTH];
    int                         shadow_count = 0;

    result_t pending_replies [$];
    int      error_count = 0;

    // Answer of the directed row now on the bus, if it has one.
    logic    row_typed = 1'b0;
    result_t row_want  = '0;

    int burst_left = 0;

    // Receiver stall pattern state.
    int rx_phase_left = 0;
    int rx_mode       = 0;

    operand_stack_engine u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Apply one command to the shadow stack and return the beat it owes.
    function automatic result_t apply_stack_command(
        input logic [ose_pkg::CMD_W-1:0]  cmd,
        input logic [ose_pkg::WORD_W-1:0] word);
        result_t r;
        logic [ose_pkg::WORD_W-1:0] held;
        r.word   = '0;
        r.status = ose_pkg::ST_OK;
        case (cmd)
            ose_pkg::CMD_PUSH: begin
                if (shadow_count < ose_pkg::STACK_DEPTH) begin
                    shadow_words[shadow_count] = word;
                    shadow_count++;
                end else begin
                    r.status = ose_pkg::ST_FULL;
                end
            end
            ose_pkg::CMD_POP: begin
                if (shadow_count > 0) begin
                    shadow_count--;
                    r.word = shadow_words[shadow_count];
                end else begin
                    r.status = ose_pkg::ST_EMPTY;
                end
            end
            ose_pkg::CMD_PEEK: begin
                if (shadow_count > 0) r.word = shadow_words[shadow_count-1];
                else r.status = ose_pkg::ST_EMPTY;
            end
            ose_pkg::CMD_DUP: begin
                // Empty wins over full; the two cannot coexist anyway.
                if (shadow_count == 0) begin
                    r.status = ose_pkg::ST_EMPTY;
                end else if (shadow_count >= ose_pkg::STACK_DEPTH) begin
                    r.status = ose_pkg::ST_FULL;
                end else begin
                    shadow_words[shadow_count] = shadow_words[shadow_count-1];
                    shadow_count++;
                end
            end
            ose_pkg::CMD_SWAP: begin
                if (shadow_count > 1) begin
                    held                         = shadow_words[shadow_count-1];
                    shadow_words[shadow_count-1] = shadow_words[shadow_count-2];
                    shadow_words[shadow_count-2] = held;
                end else begin
                    r.status = ose_pkg::ST_SHORT;
                end
            end
            ose_pkg::CMD_CLEAR: shadow_count = 0;   // contents stay, only the level drops
            default: ;                              // spare codes: leave everything alone
        endcase
        r.depth = ose_pkg::DEPTH_W'(shadow_count);
        return r;
    endfunction

    // Present one command beat; hold it until the block takes it. Open a new
    // burst when the old one runs out, sometimes with no gap in front.
    task automatic send_command(input logic [ose_pkg::CMD_W-1:0]  cmd,
                                input logic [ose_pkg::WORD_W-1:0] word,
                                input logic                       typed,
                                input result_t                    want);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {{(ose_pkg::S_TDATA_W-ose_pkg::CMD_W-ose_pkg::WORD_W){1'b0}},
                      word, cmd};
        row_typed  = typed;
        row_want   = want;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // Result side: switch between always ready, coin-flip and mostly stalled
    // phases of random length.
    always @(negedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 2);
            rx_phase_left = $urandom_range(20, 200);
        end else begin
            rx_phase_left = rx_phase_left - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Predict on every taken command beat, then check every taken result beat
    // against the oldest pending reply.
    always @(posedge aclk) begin
        result_t want;
        result_t seen;
        if (aresetn && s_tvalid && s_tready === 1'b1) begin
            want = apply_stack_command(s_tdata[ose_pkg::CMD_W-1:0],
                                       s_tdata[ose_pkg::CMD_W +: ose_pkg::WORD_W]);
            if (row_typed) want = row_want;
            pending_replies.push_back(want);
        end
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            seen.word   = m_tdata[ose_pkg::WORD_W-1:0];
            seen.status = ose_pkg::status_t'(m_tdata[ose_pkg::WORD_W +: ose_pkg::STATUS_W]);
            seen.depth  = m_tdata[ose_pkg::WORD_W+ose_pkg::STATUS_W +: ose_pkg::DEPTH_W];
            if (pending_replies.size() == 0) begin
                error_count++;
                if (error_count <= SHOW_LIMIT)
                    $display("unexpected result beat: word %h status %0d depth %0d",
                             seen.word, seen.status, seen.depth);
            end else begin
                want = pending_replies.pop_front();
                if (seen !== want) begin
                    error_count++;
                    if (error_count <= SHOW_LIMIT)
                        $display("mismatch: want %h st %0d dp %0d, got %h st %0d dp %0d",
                                 want.word, want.status, want.depth,
                                 seen.word, seen.status, seen.depth);
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial begin
        mix_t                       mix;
        int                         phase_left;
        int                         roll;
        int                         p_push;
        int                         p_dup;
        int                         p_pop;
        logic [ose_pkg::CMD_W-1:0]  cmd;
        logic [ose_pkg::WORD_W-1:0] word;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_command(DIR_TABLE[i].cmd, DIR_TABLE[i].word,
                         DIR_TABLE[i].typed, DIR_TABLE[i].want);

        // Open with a long fill phase so full is reached early.
        mix        = MIX_FILL;
        phase_left = 220;
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            if (phase_left == 0) begin
                mix        = mix_t'($urandom_range(0, 2));
                phase_left = $urandom_range(40, 220);
            end
            phase_left--;
            case (mix)
                MIX_FILL:  begin p_push = 70; p_dup = 15; p_pop = 5;  end
                MIX_DRAIN: begin p_push = 10; p_dup = 5;  p_pop = 60; end
                default:   begin p_push = 30; p_dup = 10; p_pop = 25; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < p_push) begin
                cmd = ose_pkg::CMD_PUSH;
            end else if (roll < p_push + p_dup) begin
                cmd = ose_pkg::CMD_DUP;
            end else if (roll < p_push + p_dup + p_pop) begin
                cmd = ose_pkg::CMD_POP;
            end else begin
                // Spread the remainder over peek, swap, clear and spare codes;
                // keep clear out of fill phases so the stack can top out.
                roll = $urandom_range(0, 19);
                if (roll < 8)        cmd = ose_pkg::CMD_PEEK;
                else if (roll < 16)  cmd = ose_pkg::CMD_SWAP;
                else if (roll == 16) cmd = (mix == MIX_FILL) ? ose_pkg::CMD_PEEK
                                                             : ose_pkg::CMD_CLEAR;
                else if (roll == 17) cmd = CMD_SPARE6;
                else if (roll == 18) cmd = CMD_SPARE7;
                else                 cmd = ose_pkg::CMD_PEEK;
            end
            word = {$urandom, $urandom};
            send_command(cmd, word, 1'b0, '0);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain outstanding replies, then give stray beats time to show up.
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0) begin
            $display("operand_stack_engine_tb: clean");
        end else begin
            $display("operand_stack_engine_tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #1ms;
        $display("operand_stack_engine_tb: errors");
        $finish;
    end

endmodule
